/* hdl/tlb_page_table_translator_unit_macros.svh */
// Assertion helpers shared by the translator checker.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TPTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TPTU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/tptu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tptu_pkg;

  localparam int VA_W       = 16;
  localparam int OFFSET_W   = 8;
  localparam int FCOUNT_W   = 9;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam int PAGE_COUNT_DEF = 256;
  localparam int MAX_FRAMES_DEF = 256;
  localparam int TLB_DEPTH_DEF  = 16;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 9'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 4'd1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_HRD,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_FRD,
    ST_F2,
    ST_F3,
    ST_FIN
  } tptu_state_e;

endpackage
`default_nettype wire

/* hdl/tptu_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tptu_req_if;
  import tptu_pkg::*;
  logic                valid;
  logic                ready;
  logic [VA_W-1:0]     vaddr;
  modport source (output valid, output vaddr, input ready);
  modport sink   (input valid, input vaddr, output ready);
endinterface

interface tptu_res_if;
  import tptu_pkg::*;
  logic                valid;
  logic                ready;
  logic [VA_W-1:0]     paddr;
  logic                tlb_hit;
  logic                page_fault;
  logic [CNT_W-1:0]    hit_total;
  logic [CNT_W-1:0]    fault_total;
  modport source (output valid, output paddr, output tlb_hit, output page_fault,
                  output hit_total, output fault_total, input ready);
  modport sink   (input valid, input paddr, input tlb_hit, input page_fault,
                  input hit_total, input fault_total, output ready);
endinterface

interface tptu_cfg_if;
  import tptu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/tlb_page_table_translator_unit.sv */
// Virtual to physical address translator with a TLB and a demand-paged page table.
// Channels: req_i carries one 16-bit virtual address per request, res_o returns
// one result per request (physical address, TLB hit, page fault and the two
// saturating totals), cfg_i writes the policy (index 0) and frame count (index 1).
// Flow: an accepted request goes through ST_LOOK and then ST_FIN, which loads the
// output register, for a TLB hit or a page-table hit that needs no recency update;
// an LRU page-table hit that moves its frame to the tail of the recency list also
// passes ST_HRD, ST_H2, ST_H3 and ST_H4, and a fault passes ST_FRD, ST_F2 and ST_F3.
// The block handles one request at a time; the frame memory, which holds the frame
// owners and the doubly linked recency list, has one read port and one write port.
// After reset, and after every frame count write, a clearing pass over the first
// max(PAGE_COUNT, MAX_FRAMES) addresses rebuilds both memories; req_i.ready stays
// low during it. Configuration is accepted in every cycle.
// A finished result waits in the output register while the receiver stalls;
// the next request is taken meanwhile and waits in its final step until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_table_translator_unit #(
  parameter int PAGE_COUNT = tptu_pkg::PAGE_COUNT_DEF,
  parameter int MAX_FRAMES = tptu_pkg::MAX_FRAMES_DEF,
  parameter int TLB_DEPTH  = tptu_pkg::TLB_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tptu_req_if.sink    req_i,
  tptu_res_if.source  res_o,
  tptu_cfg_if.sink    cfg_i
);
  import tptu_pkg::*;

  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int TW    = $clog2(TLB_DEPTH);
  localparam int SWEEP = (PAGE_COUNT > MAX_FRAMES) ? PAGE_COUNT : MAX_FRAMES;
  localparam int CW    = $clog2(SWEEP);
  localparam int RST_FRAMES = (int'(FCOUNT_RST) > MAX_FRAMES) ? MAX_FRAMES
                                                               : int'(FCOUNT_RST);

  typedef struct packed {
    logic          ov;
    logic [PW-1:0] op;
    logic [FW-1:0] nx;
    logic [FW-1:0] pv;
  } fent_t;

  typedef struct packed {
    logic          v;
    logic [FW-1:0] fr;
  } pent_t;

  typedef logic [TLB_DEPTH-1:0][TW-1:0] ord_t;
  typedef logic [255:0][7:0] wrap_t;

  function automatic wrap_t mk_wrap();
    wrap_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(i % PAGE_COUNT);
    end
    return t;
  endfunction

  localparam wrap_t WRAP = mk_wrap();

  function automatic ord_t ord_init();
    ord_t o;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      o[i] = TW'(i);
    end
    return o;
  endfunction

  function automatic logic [TW-1:0] ord_pos(ord_t o, logic [TW-1:0] s);
    logic [TW-1:0] p;
    p = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (o[i] == s) p = TW'(i);
    end
    return p;
  endfunction

  function automatic ord_t ord_newest(ord_t o, logic [TW-1:0] p);
    ord_t r;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (i == TLB_DEPTH - 1) r[i] = o[p];
      else if (TW'(i) >= p) r[i] = o[i+1];
      else r[i] = o[i];
    end
    return r;
  endfunction

  function automatic ord_t ord_oldest(ord_t o, logic [TW-1:0] p);
    ord_t r;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (i == 0) r[i] = o[p];
      else if (TW'(i) <= p) r[i] = o[i-1];
      else r[i] = o[i];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Memories.
  pent_t pm_mem [PAGE_COUNT];
  fent_t fm_mem [MAX_FRAMES];
  pent_t pm_rdata_q;
  fent_t fm_rdata_q;

  logic          pm_re, pm_we;
  logic [PW-1:0] pm_raddr, pm_waddr;
  pent_t         pm_wdata;
  logic          fm_re, fm_we_own, fm_we_nx, fm_we_pv;
  logic [FW-1:0] fm_raddr, fm_waddr;
  fent_t         fm_wdata;

  // State registers.
  tptu_state_e state_q, state_d;
  logic [CW-1:0]       clr_q, clr_d;
  logic [VA_W-1:0]     va_q, va_d;
  logic                policy_q, policy_d;
  logic [FCOUNT_W-1:0] nfr_q, nfr_d;
  logic [FW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]       frame_q, frame_d, prv_q, prv_d, nxt_q, nxt_d;
  logic                hit_q, hit_d, fault_q, fault_d;
  logic [CNT_W-1:0]    hcnt_q, hcnt_d, fcnt_q, fcnt_d;
  logic [TLB_DEPTH-1:0] tv_q, tv_d;
  logic [TLB_DEPTH-1:0][PW-1:0] tpg_q, tpg_d;
  logic [TLB_DEPTH-1:0][FW-1:0] tfr_q, tfr_d;
  ord_t ord_q, ord_d;
  logic                out_v_q, out_v_d;
  logic [VA_W-1:0]     out_pa_q, out_pa_d;
  logic                out_hit_q, out_hit_d, out_flt_q, out_flt_d;
  logic [CNT_W-1:0]    out_ht_q, out_ht_d, out_ft_q, out_ft_d;

  logic [PW-1:0] page;
  logic [PW-1:0] in_page;
  logic          tlb_hit_c, inv_hit_c;
  logic [TW-1:0] tlb_slot_c, inv_slot_c;
  logic          req_acc, cfg_acc, out_free;
  logic [FCOUNT_W-1:0] nfr_cfg;

  assign page     = WRAP[va_q[VA_W-1:OFFSET_W]][PW-1:0];
  assign in_page  = WRAP[req_i.vaddr[VA_W-1:OFFSET_W]][PW-1:0];
  assign req_acc  = req_i.valid && req_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_free = !out_v_q || res_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid            = out_v_q;
  assign res_o.paddr            = out_pa_q;
  assign res_o.tlb_hit          = out_hit_q;
  assign res_o.page_fault       = out_flt_q;
  assign res_o.hit_total        = out_ht_q;
  assign res_o.fault_total      = out_ft_q;

  always_comb begin
    if (cfg_i.data == '0) nfr_cfg = FCOUNT_W'(1);
    else if (cfg_i.data > FCOUNT_W'(MAX_FRAMES)) nfr_cfg = FCOUNT_W'(MAX_FRAMES);
    else nfr_cfg = cfg_i.data;
  end

  // Parallel TLB compare for the requested page and for the page being evicted.
  always_comb begin
    tlb_hit_c  = 1'b0;
    tlb_slot_c = '0;
    inv_hit_c  = 1'b0;
    inv_slot_c = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (tv_q[i] && tpg_q[i] == page) begin
        tlb_hit_c  = 1'b1;
        tlb_slot_c = TW'(i);
      end
      if (tv_q[i] && tpg_q[i] == fm_rdata_q.op) begin
        inv_hit_c  = 1'b1;
        inv_slot_c = TW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == CW'(SWEEP - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (req_acc) state_d = ST_LOOK;
      ST_LOOK: begin
        if (tlb_hit_c) state_d = ST_FIN;
        else if (pm_rdata_q.v) begin
          if (policy_q == POLICY_LRU && pm_rdata_q.fr != tail_q) state_d = ST_HRD;
          else state_d = ST_FIN;
        end else state_d = ST_FRD;
      end
      ST_HRD:   state_d = ST_H2;
      ST_H2:    state_d = ST_H3;
      ST_H3:    state_d = ST_H4;
      ST_H4:    state_d = ST_FIN;
      ST_FRD:   state_d = ST_F2;
      ST_F2:    state_d = ST_F3;
      ST_F3:    state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
    if (cfg_acc && cfg_i.index == CFG_FRAMES) state_d = ST_CLEAR;
  end

  // Datapath and memory control.
  always_comb begin
    clr_d = clr_q; va_d = va_q; policy_d = policy_q; nfr_d = nfr_q;
    head_d = head_q; tail_d = tail_q; frame_d = frame_q; prv_d = prv_q; nxt_d = nxt_q;
    hit_d = hit_q; fault_d = fault_q; hcnt_d = hcnt_q; fcnt_d = fcnt_q;
    tv_d = tv_q; tpg_d = tpg_q; tfr_d = tfr_q; ord_d = ord_q;
    out_v_d = out_v_q && !res_o.ready;
    out_pa_d = out_pa_q; out_hit_d = out_hit_q; out_flt_d = out_flt_q;
    out_ht_d = out_ht_q; out_ft_d = out_ft_q;
    pm_re = 1'b0; pm_raddr = in_page; pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0;
    fm_re = 1'b0; fm_raddr = '0; fm_we_own = 1'b0; fm_we_nx = 1'b0; fm_we_pv = 1'b0;
    fm_waddr = '0; fm_wdata = '0;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if ({1'b0, clr_q} < (CW+1)'(PAGE_COUNT)) begin
          pm_we    = 1'b1;
          pm_waddr = clr_q[PW-1:0];
        end
        if ({1'b0, clr_q} < (CW+1)'(MAX_FRAMES)) begin
          fm_we_own = 1'b1;
          fm_we_nx  = 1'b1;
          fm_we_pv  = 1'b1;
          fm_waddr  = clr_q[FW-1:0];
          fm_wdata.nx = clr_q[FW-1:0] + 1'b1;
          fm_wdata.pv = clr_q[FW-1:0] - 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          va_d  = req_i.vaddr;
          pm_re = 1'b1;
        end
      end
      ST_LOOK: begin
        if (tlb_hit_c) begin
          hit_d   = 1'b1;
          fault_d = 1'b0;
          frame_d = tfr_q[tlb_slot_c];
          hcnt_d  = sat_inc(hcnt_q);
          if (policy_q == POLICY_LRU) ord_d = ord_newest(ord_q, ord_pos(ord_q, tlb_slot_c));
        end else if (pm_rdata_q.v) begin
          hit_d    = 1'b0;
          fault_d  = 1'b0;
          frame_d  = pm_rdata_q.fr;
          fm_re    = 1'b1;
          fm_raddr = pm_rdata_q.fr;
        end else begin
          hit_d    = 1'b0;
          fault_d  = 1'b1;
          fcnt_d   = sat_inc(fcnt_q);
          frame_d  = head_q;
          fm_re    = 1'b1;
          fm_raddr = head_q;
        end
      end
      // Unlink the frame from its place in the recency list and append it at the tail.
      ST_HRD: begin
        prv_d = fm_rdata_q.pv;
        nxt_d = fm_rdata_q.nx;
        if (frame_q != head_q) begin
          fm_we_nx    = 1'b1;
          fm_waddr    = fm_rdata_q.pv;
          fm_wdata.nx = fm_rdata_q.nx;
        end
      end
      ST_H2: begin
        if (frame_q != head_q) begin
          fm_we_pv    = 1'b1;
          fm_waddr    = nxt_q;
          fm_wdata.pv = prv_q;
        end
      end
      ST_H3: begin
        fm_we_nx    = 1'b1;
        fm_waddr    = tail_q;
        fm_wdata.nx = frame_q;
      end
      ST_H4: begin
        fm_we_pv    = 1'b1;
        fm_waddr    = frame_q;
        fm_wdata.pv = tail_q;
        tail_d      = frame_q;
        if (frame_q == head_q) head_d = nxt_q;
      end
      // The victim frame's previous page loses its mapping and its TLB entry.
      ST_FRD: begin
        nxt_d = fm_rdata_q.nx;
        if (fm_rdata_q.ov) begin
          pm_we    = 1'b1;
          pm_waddr = fm_rdata_q.op;
          if (inv_hit_c) begin
            tv_d[inv_slot_c] = 1'b0;
            ord_d = ord_oldest(ord_q, ord_pos(ord_q, inv_slot_c));
          end
        end
      end
      // The victim frame goes to the tail, so its back link points at the old tail.
      ST_F2: begin
        fm_we_own   = 1'b1;
        fm_we_pv    = 1'b1;
        fm_waddr    = frame_q;
        fm_wdata.ov = 1'b1;
        fm_wdata.op = page;
        fm_wdata.pv = tail_q;
        pm_we       = 1'b1;
        pm_waddr    = page;
        pm_wdata.v  = 1'b1;
        pm_wdata.fr = frame_q;
      end
      ST_F3: begin
        if (head_q != tail_q) begin
          fm_we_nx    = 1'b1;
          fm_waddr    = tail_q;
          fm_wdata.nx = head_q;
          head_d      = nxt_q;
          tail_d      = frame_q;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_d   = 1'b1;
          out_pa_d  = {8'(frame_q), va_q[OFFSET_W-1:0]};
          out_hit_d = hit_q;
          out_flt_d = fault_q;
          out_ht_d  = hcnt_q;
          out_ft_d  = fcnt_q;
          if (!hit_q) begin
            tv_d[ord_q[0]]  = 1'b1;
            tpg_d[ord_q[0]] = page;
            tfr_d[ord_q[0]] = frame_q;
            ord_d = ord_newest(ord_q, '0);
          end
        end
      end
      default: ;
    endcase

    if (cfg_acc) begin
      if (cfg_i.index == CFG_POLICY) begin
        policy_d = cfg_i.data[0];
      end else if (cfg_i.index == CFG_FRAMES) begin
        nfr_d  = nfr_cfg;
        clr_d  = '0;
        head_d = '0;
        tail_d = FW'(nfr_cfg - 1'b1);
        tv_d   = '0;
        ord_d  = ord_init();
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      policy_q <= POLICY_LRU;
      nfr_q    <= FCOUNT_RST;
      head_q   <= '0;
      tail_q   <= FW'(RST_FRAMES - 1);
      hcnt_q   <= '0;
      fcnt_q   <= '0;
      tv_q     <= '0;
      ord_q    <= ord_init();
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      policy_q <= policy_d;
      nfr_q    <= nfr_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      hcnt_q   <= hcnt_d;
      fcnt_q   <= fcnt_d;
      tv_q     <= tv_d;
      ord_q    <= ord_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q      <= va_d;
    frame_q   <= frame_d;
    prv_q     <= prv_d;
    nxt_q     <= nxt_d;
    hit_q     <= hit_d;
    fault_q   <= fault_d;
    tpg_q     <= tpg_d;
    tfr_q     <= tfr_d;
    out_pa_q  <= out_pa_d;
    out_hit_q <= out_hit_d;
    out_flt_q <= out_flt_d;
    out_ht_q  <= out_ht_d;
    out_ft_q  <= out_ft_d;
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    if (pm_re) pm_rdata_q <= pm_mem[pm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fm_we_own) begin
      fm_mem[fm_waddr].ov <= fm_wdata.ov;
      fm_mem[fm_waddr].op <= fm_wdata.op;
    end
    if (fm_we_nx) fm_mem[fm_waddr].nx <= fm_wdata.nx;
    if (fm_we_pv) fm_mem[fm_waddr].pv <= fm_wdata.pv;
    if (fm_re) fm_rdata_q <= fm_mem[fm_raddr];
  end

endmodule
`default_nettype wire

/* hdl/tptu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_page_table_translator_unit_macros.svh"
module tptu_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        res_valid_i,
  input wire        res_ready_i,
  input wire        res_hit_i,
  input wire        res_fault_i,
  input wire [31:0] res_hit_total_i,
  input wire [31:0] res_fault_total_i
);

  `TPTU_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")
  `TPTU_ASSERT(a_hit_xor_fault, res_valid_i |-> !(res_hit_i && res_fault_i), "hit and fault together")
  `TPTU_ASSERT(a_hit_total, res_valid_i && res_hit_i |-> res_hit_total_i != 32'd0, "hit not counted")
  `TPTU_ASSERT(a_fault_total, res_valid_i && res_fault_i |-> res_fault_total_i != 32'd0, "fault not counted")

endmodule

bind tlb_page_table_translator_unit tptu_checker u_tptu_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_hit_i         (res_o.tlb_hit),
  .res_fault_i       (res_o.page_fault),
  .res_hit_total_i   (res_o.hit_total),
  .res_fault_total_i (res_o.fault_total)
);
`default_nettype wire

/* bench/tptu_tb_pkg.sv */
`timescale 1ns / 1ps
package tptu_tb_pkg;
  import tptu_pkg::*;

  typedef struct packed {
    logic [VA_W-1:0]  phys;
    logic             hit;
    logic             fault;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] faults;
  } xlate_t;

  // Translation predictor plus the queue of pending expected results.
  class xlate_scoreboard;
    bit          lru;
    int          nframes;
    logic [8:0]  pmap [256];
    logic [8:0]  owner [256];
    logic [7:0]  forder [256];
    logic [16:0] tlb [16];
    logic [3:0]  torder [16];
    logic [31:0] hits, faults;
    xlate_t      pending [$];
    int          errors;
    int          n_hit, n_fault;

    function new();
      lru = POLICY_LRU;
      hits = 0;
      faults = 0;
      errors = 0;
      flush(9'd128);
    endfunction

    function void flush(logic [8:0] fc);
      nframes = (fc == 0) ? 1 : (fc > 256 ? 256 : fc);
      for (int i = 0; i < 256; i++) begin
        pmap[i] = 0;
        owner[i] = 0;
        forder[i] = 8'(i);
      end
      for (int i = 0; i < 16; i++) begin
        tlb[i] = 0;
        torder[i] = 4'(i);
      end
    endfunction

    function void write_reg(logic [3:0] idx, logic [8:0] d);
      if (idx == CFG_POLICY) lru = d[0];
      else if (idx == CFG_FRAMES) flush(d);
    endfunction

    function int tlb_find(logic [7:0] pg);
      for (int i = 0; i < 16; i++)
        if (tlb[i][16] && tlb[i][15:8] == pg) return i;
      return 16;
    endfunction

    function void tlb_newest(int pos);
      logic [3:0] v;
      v = torder[pos];
      for (int i = pos; i < 15; i++) torder[i] = torder[i+1];
      torder[15] = v;
    endfunction

    function void frame_newest(int pos);
      logic [7:0] v;
      v = forder[pos];
      for (int i = pos; i < nframes - 1; i++) forder[i] = forder[i+1];
      forder[nframes-1] = v;
    endfunction

    function void note_request(logic [15:0] va);
      xlate_t r;
      logic [7:0] pg, fr, old;
      int s, p;
      pg = va[15:8];
      r = '0;
      s = tlb_find(pg);
      if (s < 16) begin
        r.hit = 1;
        n_hit++;
        if (hits != 32'hFFFF_FFFF) hits++;
        fr = tlb[s][7:0];
        if (lru) begin
          for (p = 0; p < 16; p++) if (torder[p] == s) break;
          tlb_newest(p);
        end
      end else begin
        if (pmap[pg][8]) begin
          fr = pmap[pg][7:0];
          if (lru) begin
            for (p = 0; p < nframes; p++) if (forder[p] == fr) break;
            if (p < nframes) frame_newest(p);
          end
        end else begin
          r.fault = 1;
          n_fault++;
          if (faults != 32'hFFFF_FFFF) faults++;
          fr = forder[0];
          if (owner[fr][8]) begin
            old = owner[fr][7:0];
            pmap[old] = 0;
            s = tlb_find(old);
            if (s < 16) begin
              logic [3:0] v;
              tlb[s] = 0;
              for (p = 0; p < 16; p++) if (torder[p] == s) break;
              v = torder[p];
              for (int i = p; i > 0; i--) torder[i] = torder[i-1];
              torder[0] = v;
            end
          end
          owner[fr] = {1'b1, pg};
          pmap[pg] = {1'b1, fr};
          frame_newest(0);
        end
        tlb[torder[0]] = {1'b1, pg, fr};
        tlb_newest(0);
      end
      r.phys = {fr, va[7:0]};
      r.hits = hits;
      r.faults = faults;
      pending.push_back(r);
    endfunction

    function void check_result(xlate_t got);
      xlate_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass
endpackage

/* bench/tlb_page_table_translator_unit_tb.sv */
`timescale 1ns / 1ps
module tlb_page_table_translator_unit_tb;
  import tptu_pkg::*;
  import tptu_tb_pkg::*;

  logic clk_i, rst_ni;
  tptu_req_if req ();
  tptu_res_if res ();
  tptu_cfg_if cfg ();

  tlb_page_table_translator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req.sink), .res_o(res.source), .cfg_i(cfg.sink)
  );

  xlate_scoreboard sb;
  bit calm;
  int cycles;
  logic [7:0] hot [$];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, then checks each accepted result.
  initial begin
    int gap;
    res.ready = 0;
    gap = 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready)
        sb.check_result({res.paddr, res.tlb_hit, res.page_fault,
                         res.hit_total, res.fault_total});
      if (gap > 0) gap--;
      else if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
      res.ready <= (gap == 0);
    end
  end

  // Valid stays high after acceptance until the next request or an idle gap replaces it.
  task automatic send_va(logic [15:0] va);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req.valid <= 1;
    req.vaddr <= va;
    @(posedge clk_i iff req.ready);
    sb.note_request(va);
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk_i iff sb.pending.size() == 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [8:0] d);
    drain();
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk_i iff cfg.ready);
    sb.write_reg(idx, d);
    cfg.valid <= 0;
  endtask

  // Mostly reuse a small working set so TLB and page-table hits occur.
  function automatic logic [15:0] pick_va(int span);
    logic [7:0] pg;
    if (hot.size() > 0 && $urandom_range(0, 3) != 0)
      pg = hot[$urandom_range(0, hot.size() - 1)];
    else begin
      pg = 8'($urandom_range(0, span));
      hot.push_back(pg);
      if (hot.size() > 24) void'(hot.pop_front());
    end
    return {pg, 8'($urandom)};
  endfunction

  task automatic phase(logic pol, logic [8:0] fc, int n, int span);
    write_reg(CFG_POLICY, {8'd0, pol});
    write_reg(CFG_FRAMES, fc);
    hot.delete();
    repeat (n) send_va(pick_va(span));
  endtask

  initial begin
    sb = new();
    calm = 0;
    rst_ni = 0;
    req.valid = 0;
    req.vaddr = 0;
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    // Directed: extremes, repeats for hits, eviction with few frames.
    send_va(16'h0000);
    send_va(16'hFFFF);
    send_va(16'h00FF);
    send_va(16'hFF00);
    send_va(16'h5AA5);
    send_va(16'hA55A);
    write_reg(CFG_FRAMES, 9'd0);
    send_va(16'h1234);
    send_va(16'h2234);
    send_va(16'h1299);
    write_reg(CFG_FRAMES, 9'd511);
    for (int i = 0; i < 18; i++) send_va({8'(i), 8'(i * 13)});
    send_va(16'h0001);
    // Unknown register index must be ignored.
    write_reg(4'd9, 9'h1FF);
    send_va(16'h0102);
    write_reg(CFG_FRAMES, 9'd3);
    write_reg(CFG_POLICY, {8'd0, POLICY_FIFO});
    for (int i = 0; i < 8; i++) send_va({8'(i % 5), 8'hC3});
    drain();
    phase(POLICY_LRU, 9'd4, 250, 12);
    phase(POLICY_FIFO, 9'd4, 250, 12);
    phase(POLICY_LRU, 9'd1, 150, 6);
    phase(POLICY_FIFO, 9'd20, 250, 60);
    phase(POLICY_LRU, 9'd256, 250, 255);
    phase(POLICY_LRU, 9'd17, 200, 40);
    // Policy switch without a flush.
    write_reg(CFG_POLICY, {8'd0, POLICY_FIFO});
    calm = 1;
    repeat (250) send_va(pick_va(40));
    drain();
    $display("Covered %0d hits and %0d faults over LRU and FIFO with 1 to 256 frames.",
             sb.n_hit, sb.n_fault);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
